FILE: hdl/se3_pkg.sv
package se3_pkg;

  typedef logic signed [63:0] s64_t;
  typedef logic signed [33:0] s34_t;

  typedef struct packed {
    logic [31:0] axis_x;
    logic [31:0] axis_y;
    logic [31:0] axis_z;
    logic [31:0] lin_x;
    logic [31:0] lin_y;
    logic [31:0] lin_z;
    logic [31:0] joint_value;
  } screw_t;

  typedef struct packed {
    logic [31:0] rot_00;
    logic [31:0] rot_01;
    logic [31:0] rot_02;
    logic [31:0] rot_10;
    logic [31:0] rot_11;
    logic [31:0] rot_12;
    logic [31:0] rot_20;
    logic [31:0] rot_21;
    logic [31:0] rot_22;
    logic [31:0] trans_x;
    logic [31:0] trans_y;
    logic [31:0] trans_z;
  } xform_t;

  typedef enum logic [1:0] {QUAD0, QUAD1, QUAD2, QUAD3} quad_t;

  // pipeline stage contents
  typedef struct packed {
    logic                   prism;
    quad_t                  quad;
    logic [2:0][31:0]       w;
    logic [2:0][31:0]       v;
    logic [31:0]            th;
    logic [63:0]            klo;
    logic [63:0]            khi;
    logic [2:0][2:0][63:0]  wv;
    logic [2:0][2:0][63:0]  ww;
    logic [2:0][63:0]       vt;
    logic [31:0]            p;
    logic [2:0][31:0]       c;
    logic [31:0]            d;
    logic [31:0]            dt;
    logic [2:0][2:0][33:0]  w2;
    logic [2:0][31:0]       tp;
    logic [63:0]            pp;
    logic [63:0]            dth;
    logic [31:0]            a;
    logic [63:0]            aa;
    logic [31:0]            a2;
    logic [31:0]            ts;
    logic [31:0]            ss;
    logic [31:0]            tc;
    logic [31:0]            sc;
    logic [63:0]            ps;
    logic [63:0]            pc;
    logic                   ns_neg;
    logic                   nc_neg;
    logic [31:0]            ms;
    logic [31:0]            mc;
    logic [63:0]            qs0;
    logic [63:0]            qc0;
    logic [2:0][2:0][63:0]  rsp;
    logic [2:0][2:0][63:0]  rop;
    logic [2:0][2:0][31:0]  r;
    logic [2:0][2:0][63:0]  mt;
    logic [2:0][63:0]       pdw;
    logic [2:0][31:0]       t;
  } pipe_t;

  localparam int NST   = 28;
  localparam int ITER0 = 6;
  localparam int NITER = 6;

  localparam s34_t        ONE_Q30    = 34'sd1073741824;
  localparam s34_t        TWO_PI_Q30 = 34'sd6746518852;
  localparam logic [63:0] K_TURN     = 64'd44798133900177;
  localparam int          K_SPLIT    = 23;
  localparam s34_t        K_LO       = s34_t'(K_TURN[K_SPLIT-1:0]);
  localparam s34_t        K_HI       = s34_t'(K_TURN >> K_SPLIT);
  localparam logic [31:0] HALF_QTR   = 32'h2000_0000;

  localparam logic [7:0] DIV_SIN [NITER] = '{8'd6, 8'd20, 8'd42, 8'd72, 8'd110, 8'd156};
  localparam logic [7:0] DIV_COS [NITER] = '{8'd2, 8'd12, 8'd30, 8'd56, 8'd90, 8'd132};
  // floor(2^32 / divisor)
  localparam s34_t REC_SIN [NITER] = '{34'sd715827882, 34'sd214748364, 34'sd102261126,
                                       34'sd59652323, 34'sd39045157, 34'sd27531841};
  localparam s34_t REC_COS [NITER] = '{34'sd2147483648, 34'sd357913941, 34'sd143165576,
                                       34'sd76695844, 34'sd47721858, 34'sd32537631};

  function automatic s34_t x34(input logic [31:0] x);
    return s34_t'($signed(x));
  endfunction

  function automatic logic [63:0] mul(input s34_t a, input s34_t b);
    logic signed [67:0] m;
    m = a * b;
    return m[63:0];
  endfunction

  // round half up, then arithmetic shift
  function automatic s64_t rnd(input s64_t x, input int unsigned n);
    return (x + (s64_t'(1) <<< (n - 1))) >>> n;
  endfunction

  function automatic logic [31:0] sat32(input s64_t x);
    logic [31:0] y;
    if (x > s64_t'(64'sd2147483647)) begin
      y = 32'h7fff_ffff;
    end else if (x < -s64_t'(64'sd2147483648)) begin
      y = 32'h8000_0000;
    end else begin
      y = x[31:0];
    end
    return y;
  endfunction

  function automatic logic [31:0] clamp30(input s64_t x);
    logic [31:0] y;
    if (x > s64_t'(ONE_Q30)) begin
      y = 32'h4000_0000;
    end else if (x < -s64_t'(ONE_Q30)) begin
      y = 32'hc000_0000;
    end else begin
      y = x[31:0];
    end
    return y;
  endfunction

endpackage

FILE: hdl/se3_screw_exponential.sv
// SE(3) exponential of a joint screw.
// Input channel item_valid/item_ready carries one screw word: axis (Q2.30),
// linear part (Q16.16) and joint value (Q16.16). Output channel
// xform_valid/xform_ready carries the 3x4 transform: rotation in Q2.30 and
// saturated translation in Q16.16. A zero axis gives identity rotation and
// a translation of lin * joint_value.
// A word passes through 28 register stages (the first loads at acceptance):
// angle reduction, six Taylor steps of three stages each (multiply,
// reciprocal multiply, remainder correction), rotation assembly and the
// translation products and sum. Throughput is one word per cycle while
// the output is not stalled. Each stage holds its own valid bit and
// advances when the stage after it is empty or moving, so bubbles close up
// and a stall at the output backs up stage by stage without dropping or
// repeating a word; item_ready stays high while any stage is empty.
// Reset (rst, synchronous) clears every valid bit; no result is pending.
module se3_screw_exponential
  import se3_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   item_valid,
  output logic   item_ready,
  input  screw_t item,
  output logic   xform_valid,
  input  logic   xform_ready,
  output xform_t xform
);

  pipe_t st [NST];
  pipe_t nx [NST];
  logic   vld [NST];
  logic [NST-1:0] en;

  always_comb begin
    en[NST-1] = !vld[NST-1] || xform_ready;
    for (int s = NST - 2; s >= 0; s--) begin
      en[s] = !vld[s] || en[s+1];
    end
  end

  assign item_ready = en[0];

  for (genvar S = 0; S < NST; S++) begin : g_st

    if (S == 0) begin : g_in
      always_comb begin
        logic [2:0][31:0] ax;
        nx[S] = '0;
        ax = {item.axis_z, item.axis_y, item.axis_x};
        for (int i = 0; i < 3; i++) begin
          nx[S].w[i] = clamp30(s64_t'($signed(ax[i])));
        end
        nx[S].v  = {item.lin_z, item.lin_y, item.lin_x};
        nx[S].th = item.joint_value;
        nx[S].prism = (ax == '0);
      end
    end else if (S == 1) begin : g_prod
      always_comb begin
        nx[S] = st[S-1];
        nx[S].klo = mul(x34(st[S-1].th), K_LO);
        nx[S].khi = mul(x34(st[S-1].th), K_HI);
        for (int i = 0; i < 3; i++) begin
          for (int j = 0; j < 3; j++) begin
            nx[S].wv[i][j] = mul(x34(st[S-1].w[i]), x34(st[S-1].v[j]));
            nx[S].ww[i][j] = mul(x34(st[S-1].w[i]), x34(st[S-1].w[j]));
          end
          nx[S].vt[i] = mul(x34(st[S-1].v[i]), x34(st[S-1].th));
        end
      end
    end else if (S == 2) begin : g_reduce
      always_comb begin
        logic [63:0] u;
        logic [63:0] r;
        pipe_t       x;
        x = st[S-1];
        nx[S] = x;
        u = (x.khi << K_SPLIT) + x.klo;
        r = u + (64'd1 << 61);
        nx[S].quad = quad_t'(r[63:62]);
        nx[S].p = {2'b00, r[61:32]} - HALF_QTR;
        nx[S].c[0] = sat32(rnd(x.wv[1][2] - x.wv[2][1], 30));
        nx[S].c[1] = sat32(rnd(x.wv[2][0] - x.wv[0][2], 30));
        nx[S].c[2] = sat32(rnd(x.wv[0][1] - x.wv[1][0], 30));
        nx[S].d = sat32(rnd(x.wv[0][0] + x.wv[1][1] + x.wv[2][2], 30));
        for (int i = 0; i < 3; i++) begin
          for (int j = 0; j < 3; j++) begin
            nx[S].w2[i][j] = 34'(rnd(x.ww[i][j], 30));
          end
          nx[S].tp[i] = sat32(rnd(x.vt[i], 16));
        end
        nx[S].w2[0][0] = 34'(rnd(-(x.ww[1][1] + x.ww[2][2]), 30));
        nx[S].w2[1][1] = 34'(rnd(-(x.ww[2][2] + x.ww[0][0]), 30));
        nx[S].w2[2][2] = 34'(rnd(-(x.ww[0][0] + x.ww[1][1]), 30));
      end
    end else if (S == 3) begin : g_ang
      always_comb begin
        nx[S] = st[S-1];
        nx[S].pp  = mul(x34(st[S-1].p), TWO_PI_Q30);
        nx[S].dth = mul(x34(st[S-1].d), x34(st[S-1].th));
      end
    end else if (S == 4) begin : g_sq
      always_comb begin
        logic [31:0] a;
        nx[S] = st[S-1];
        a = 32'(rnd(st[S-1].pp, 32));
        nx[S].a  = a;
        nx[S].aa = mul(x34(a), x34(a));
        nx[S].dt = sat32(rnd(st[S-1].dth, 16));
      end
    end else if (S == 5) begin : g_init
      always_comb begin
        nx[S] = st[S-1];
        nx[S].a2 = 32'(rnd(st[S-1].aa, 30));
        nx[S].ts = st[S-1].a;
        nx[S].ss = st[S-1].a;
        nx[S].tc = ONE_Q30[31:0];
        nx[S].sc = ONE_Q30[31:0];
      end
    end else if (S < ITER0 + 3 * NITER) begin : g_iter
      localparam int IT = (S - ITER0) / 3;
      localparam int PH = (S - ITER0) % 3;
      if (PH == 0) begin : g_mul
        always_comb begin
          nx[S] = st[S-1];
          nx[S].ps = mul(x34(st[S-1].ts), x34(st[S-1].a2));
          nx[S].pc = mul(x34(st[S-1].tc), x34(st[S-1].a2));
        end
      end else if (PH == 1) begin : g_recip
        always_comb begin
          s64_t ns;
          s64_t nc;
          logic [63:0] ms;
          logic [63:0] mc;
          nx[S] = st[S-1];
          ns = rnd(st[S-1].ps, 30);
          nc = rnd(st[S-1].pc, 30);
          ms = ns[63] ? -ns : ns;
          mc = nc[63] ? -nc : nc;
          nx[S].ns_neg = ns[63];
          nx[S].nc_neg = nc[63];
          nx[S].ms = ms[31:0];
          nx[S].mc = mc[31:0];
          nx[S].qs0 = mul({2'b00, ms[31:0]}, REC_SIN[IT]);
          nx[S].qc0 = mul({2'b00, mc[31:0]}, REC_COS[IT]);
        end
      end else begin : g_fix
        always_comb begin
          logic [31:0] q0s;
          logic [31:0] q0c;
          logic [39:0] pds;
          logic [39:0] pdc;
          logic [31:0] rs;
          logic [31:0] rc;
          logic [31:0] qs;
          logic [31:0] qc;
          logic [31:0] ts;
          logic [31:0] tc;
          nx[S] = st[S-1];
          q0s = st[S-1].qs0[63:32];
          q0c = st[S-1].qc0[63:32];
          pds = {8'b0, q0s} * {32'b0, DIV_SIN[IT]};
          pdc = {8'b0, q0c} * {32'b0, DIV_COS[IT]};
          rs = st[S-1].ms - pds[31:0];
          rc = st[S-1].mc - pdc[31:0];
          qs = q0s + {31'b0, rs >= {24'b0, DIV_SIN[IT]}};
          qc = q0c + {31'b0, rc >= {24'b0, DIV_COS[IT]}};
          ts = st[S-1].ns_neg ? qs : -qs;
          tc = st[S-1].nc_neg ? qc : -qc;
          nx[S].ts = ts;
          nx[S].tc = tc;
          nx[S].ss = st[S-1].ss + ts;
          nx[S].sc = st[S-1].sc + tc;
        end
      end
    end else if (S == ITER0 + 3 * NITER) begin : g_rmul
      always_comb begin
        logic [31:0] sn;
        logic [31:0] cs;
        s34_t oc;
        s34_t wm [3][3];
        pipe_t x;
        x = st[S-1];
        nx[S] = x;
        case (x.quad)
          QUAD0: begin
            sn = x.ss;
            cs = x.sc;
          end
          QUAD1: begin
            sn = x.sc;
            cs = -x.ss;
          end
          QUAD2: begin
            sn = -x.ss;
            cs = -x.sc;
          end
          default: begin
            sn = -x.sc;
            cs = x.ss;
          end
        endcase
        oc = ONE_Q30 - x34(cs);
        wm[0][0] = '0;            wm[0][1] = -x34(x.w[2]); wm[0][2] = x34(x.w[1]);
        wm[1][0] = x34(x.w[2]);   wm[1][1] = '0;           wm[1][2] = -x34(x.w[0]);
        wm[2][0] = -x34(x.w[1]);  wm[2][1] = x34(x.w[0]);  wm[2][2] = '0;
        for (int i = 0; i < 3; i++) begin
          for (int j = 0; j < 3; j++) begin
            nx[S].rsp[i][j] = mul(x34(sn), wm[i][j]);
            nx[S].rop[i][j] = mul(oc, $signed(x.w2[i][j]));
          end
        end
      end
    end else if (S == ITER0 + 3 * NITER + 1) begin : g_rot
      always_comb begin
        s64_t idm;
        nx[S] = st[S-1];
        for (int i = 0; i < 3; i++) begin
          for (int j = 0; j < 3; j++) begin
            idm = (i == j) ? s64_t'(ONE_Q30) : '0;
            if (st[S-1].prism) begin
              nx[S].r[i][j] = idm[31:0];
            end else begin
              nx[S].r[i][j] = clamp30(idm + rnd(st[S-1].rsp[i][j], 30)
                                      + rnd(st[S-1].rop[i][j], 30));
            end
          end
        end
      end
    end else if (S == ITER0 + 3 * NITER + 2) begin : g_tmul
      always_comb begin
        s34_t imr;
        nx[S] = st[S-1];
        for (int i = 0; i < 3; i++) begin
          for (int j = 0; j < 3; j++) begin
            imr = ((i == j) ? ONE_Q30 : '0) - x34(st[S-1].r[i][j]);
            nx[S].mt[i][j] = mul(imr, x34(st[S-1].c[j]));
          end
          nx[S].pdw[i] = mul(x34(st[S-1].dt), x34(st[S-1].w[i]));
        end
      end
    end else begin : g_tsum
      always_comb begin
        s64_t acc;
        nx[S] = st[S-1];
        for (int i = 0; i < 3; i++) begin
          acc = rnd(st[S-1].pdw[i], 30);
          for (int j = 0; j < 3; j++) begin
            acc = acc + rnd(st[S-1].mt[i][j], 30);
          end
          nx[S].t[i] = st[S-1].prism ? st[S-1].tp[i] : sat32(acc);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[S] <= 1'b0;
      end else if (en[S]) begin
        vld[S] <= (S == 0) ? item_valid : vld[(S == 0) ? 0 : S - 1];
      end
    end

    always_ff @(posedge clk) begin
      if (en[S]) begin
        st[S] <= nx[S];
      end
    end

  end

  assign xform_valid = vld[NST-1];

  always_comb begin
    xform.rot_00  = st[NST-1].r[0][0];
    xform.rot_01  = st[NST-1].r[0][1];
    xform.rot_02  = st[NST-1].r[0][2];
    xform.rot_10  = st[NST-1].r[1][0];
    xform.rot_11  = st[NST-1].r[1][1];
    xform.rot_12  = st[NST-1].r[1][2];
    xform.rot_20  = st[NST-1].r[2][0];
    xform.rot_21  = st[NST-1].r[2][1];
    xform.rot_22  = st[NST-1].r[2][2];
    xform.trans_x = st[NST-1].t[0];
    xform.trans_y = st[NST-1].t[1];
    xform.trans_z = st[NST-1].t[2];
  end

endmodule

FILE: hdl/se3_chk.sv
module se3_chk
  import se3_pkg::*;
(
  input logic   clk,
  input logic   rst,
  input logic   item_ready,
  input logic   xform_valid,
  input logic   xform_ready,
  input xform_t xform
);

  function automatic logic rot_ok(input logic [31:0] x);
    return $signed(x) <= 32'sd1073741824 && $signed(x) >= -32'sd1073741824;
  endfunction

  a_hold: assert property (@(posedge clk) disable iff (rst)
    xform_valid && !xform_ready |=> xform_valid)
    else $error("result word dropped while stalled");

  a_stable: assert property (@(posedge clk) disable iff (rst)
    xform_valid && !xform_ready |=> $stable(xform))
    else $error("result word changed while stalled");

  a_reset: assert property (@(posedge clk) rst |=> !xform_valid)
    else $error("result valid after reset");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    !xform_valid |-> item_ready)
    else $error("input blocked with empty output");

  a_range: assert property (@(posedge clk) disable iff (rst)
    xform_valid |-> rot_ok(xform.rot_00) && rot_ok(xform.rot_01) && rot_ok(xform.rot_02)
      && rot_ok(xform.rot_10) && rot_ok(xform.rot_11) && rot_ok(xform.rot_12)
      && rot_ok(xform.rot_20) && rot_ok(xform.rot_21) && rot_ok(xform.rot_22))
    else $error("rotation entry out of range");

endmodule

bind se3_screw_exponential se3_chk u_se3_chk (
  .clk         (clk),
  .rst         (rst),
  .item_ready  (item_ready),
  .xform_valid (xform_valid),
  .xform_ready (xform_ready),
  .xform       (xform)
);
